>>> rtl/core/ipv6_udp_redirect_classifier_macros.svh
// Assertion macros shared by the classifier RTL.
`ifndef IPV6_UDP_REDIRECT_CLASSIFIER_MACROS_SVH
`define IPV6_UDP_REDIRECT_CLASSIFIER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IURC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ipv6_udp_redirect_classifier: check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define IURC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ipv6_udp_redirect_classifier: check failed");

`endif

>>> rtl/core/ipv6urc_pkg.sv
// Types and constants of the IPv6/UDP redirect classifier.
package ipv6urc_pkg;

  // frame layout (byte offsets in wire order)
  localparam int unsigned MIN_FRAME_LEN  = 62;
  localparam int unsigned ETYPE_OFS      = 12;
  localparam int unsigned NEXT_HDR_OFS   = 20;
  localparam int unsigned IP6_HDR_OFS    = 14;
  localparam int unsigned IP6_DST_IN_HDR = 24;
  localparam int unsigned DST_ADDR_OFS   = IP6_HDR_OFS + IP6_DST_IN_HDR;
  localparam int unsigned ADDR_BYTES     = 16;
  localparam int unsigned DST_PORT_OFS   = 56;

  localparam logic [7:0] ETYPE_HI  = 8'h86;
  localparam logic [7:0] ETYPE_LO  = 8'hDD;
  localparam logic [7:0] UDP_PROTO = 8'd17;

  localparam int unsigned QMASK_W = 16;

  // register decode: paddr[2] selects the register
  localparam logic REG_QMASK = 1'b0;

  // front-to-back token queue
  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned MID_PTR_W = (MID_DEPTH > 1) ? $clog2(MID_DEPTH) : 1;
  localparam int unsigned MID_CNT_W = $clog2(MID_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_BYTE = 2'd0,
    MODE_ADDR = 2'd1,
    MODE_PORT = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    VERDICT_PASS     = 2'd0,
    VERDICT_REDIRECT = 2'd1,
    VERDICT_DROP     = 2'd2
  } verdict_e;

  // what the front knows about a finished frame
  typedef struct packed {
    logic       cand;      // long enough, IPv6, UDP, address hit
    logic       port_hit;  // destination port in the port table
    logic [3:0] rx_queue;
  } token_t;

endpackage

>>> rtl/core/ipv6_udp_redirect_classifier.sv
// Top level of the IPv6/UDP redirect classifier.
//
// Input channel (queue style): push/full. Each item is a frame byte
// (mode 0), an address-table write (mode 1) or a port-table write (mode 2).
// Frame bytes come in wire order; the byte with end_of_packet set closes
// the frame and yields exactly one verdict item. Table writes and other
// bytes yield nothing.
// Result channel: empty/pop. verdict_o/target_queue_o show the oldest
// verdict while empty is low.
// Throughput: one item per cycle while full is low. A verdict's token is
// written into the token queue at the edge that takes its final byte and
// is loaded into the back output register once that register is free;
// the verdict is on the result ports from then on.
// Stall: a two-entry token queue sits between the front parser and the
// back verdict stage. When pop is held low the queue fills and full
// rises; every item kind waits, not only final bytes. Input resumes at
// the edge after the one that takes a result.
// Reset: rst_ni clears the parse state, all table valid bits and the
// queue-ready mask; table contents stay undefined until written.
// Config: APB register 0 (byte address 0) is queue_ready_mask; write it
// only while no frame is in flight.
`include "ipv6_udp_redirect_classifier_macros.svh"
module ipv6_udp_redirect_classifier import ipv6urc_pkg::*; #(
  parameter int unsigned ADDRESS_ENTRIES = 16,
  parameter int unsigned PORT_ENTRIES    = 16,
  parameter int unsigned QUEUE_COUNT     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input queue
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  pkt_byte_i,
  input  logic        end_of_packet_i,
  input  logic [3:0]  rx_queue_i,
  input  logic [3:0]  slot_i,
  input  logic [63:0] key_high_i,
  input  logic [63:0] key_low_i,
  input  logic [15:0] port_key_i,
  input  logic        entry_valid_i,
  // result queue
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  verdict_o,
  output logic [3:0]  target_queue_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               accept;
  logic               tok_push, tok_pop;
  logic               fifo_full, fifo_empty;
  token_t             tok_in, tok_out;
  logic [QMASK_W-1:0] qmask_q;

  assign accept = push && !full;
  assign full   = fifo_full;

  // APB register: always ready, paddr[2] picks the register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_QMASK) ? {16'd0, qmask_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qmask_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_QMASK)) begin
      qmask_q <= pwdata[QMASK_W-1:0];
    end
  end

  ipv6urc_front #(
    .ADDRESS_ENTRIES (ADDRESS_ENTRIES),
    .PORT_ENTRIES    (PORT_ENTRIES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .mode_i          (mode_i),
    .pkt_byte_i      (pkt_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .rx_queue_i      (rx_queue_i),
    .slot_i          (slot_i),
    .key_high_i      (key_high_i),
    .key_low_i       (key_low_i),
    .port_key_i      (port_key_i),
    .entry_valid_i   (entry_valid_i),
    .tok_push_o      (tok_push),
    .tok_o           (tok_in)
  );

  ipv6urc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tok_push),
    .data_i  (tok_in),
    .full_o  (fifo_full),
    .pop_i   (tok_pop),
    .data_o  (tok_out),
    .empty_o (fifo_empty)
  );

  ipv6urc_back #(
    .QUEUE_COUNT (QUEUE_COUNT)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .tok_i              (tok_out),
    .tok_valid_i        (!fifo_empty),
    .tok_pop_o          (tok_pop),
    .queue_ready_mask_i (qmask_q),
    .pop_i              (pop),
    .empty_o            (empty),
    .verdict_o          (verdict_o),
    .target_queue_o     (target_queue_o)
  );

  // a token is never offered to a full queue
  `IURC_ASSERT_IMP(a_no_push_when_full, tok_push, !fifo_full)
  // a nonzero target only comes with a redirect
  `IURC_ASSERT_IMP(a_target_only_redirect, !empty && (target_queue_o != 4'd0),
                   verdict_o == VERDICT_REDIRECT)
  // a token moved into the back stage shows up as a result next cycle
  `IURC_ASSERT_NXT(a_token_lands, tok_pop, !empty)

endmodule

>>> rtl/core/ipv6urc_front.sv
// Front part: frame byte parser, address/port tables, per-frame token.
module ipv6urc_front import ipv6urc_pkg::*; #(
  parameter int unsigned ADDRESS_ENTRIES = 16,
  parameter int unsigned PORT_ENTRIES    = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [1:0]   mode_i,
  input  logic [7:0]   pkt_byte_i,
  input  logic         end_of_packet_i,
  input  logic [3:0]   rx_queue_i,
  input  logic [3:0]   slot_i,
  input  logic [63:0]  key_high_i,
  input  logic [63:0]  key_low_i,
  input  logic [15:0]  port_key_i,
  input  logic         entry_valid_i,
  output logic         tok_push_o,
  output token_t       tok_o
);

  logic [5:0]                 pos_q, pos_d;
  logic                       eth_q, eth_d;
  logic                       udp_q, udp_d;
  logic [ADDRESS_ENTRIES-1:0] amatch_q, amatch_d;
  logic [7:0]                 phi_q, phi_d;
  logic [15:0]                pcap_q, pcap_d;

  logic [127:0]               akey_q [ADDRESS_ENTRIES];
  logic [ADDRESS_ENTRIES-1:0] aval_q;
  logic [15:0]                pkey_q [PORT_ENTRIES];
  logic [PORT_ENTRIES-1:0]    pval_q;
  logic [PORT_ENTRIES-1:0]    phit;

  logic       byte_acc, eop_acc, addr_wr, port_wr, in_addr;
  logic [3:0] abyte_idx;

  assign byte_acc  = accept_i && (mode_i == MODE_BYTE);
  assign eop_acc   = byte_acc && end_of_packet_i;
  assign addr_wr   = accept_i && (mode_i == MODE_ADDR);
  assign port_wr   = accept_i && (mode_i == MODE_PORT);
  assign in_addr   = (pos_q >= 6'(DST_ADDR_OFS)) && (pos_q < 6'(DST_ADDR_OFS + ADDR_BYTES));
  assign abyte_idx = 4'(pos_q - 6'(DST_ADDR_OFS));

  // per-frame parse state
  always_comb begin
    pos_d    = pos_q;
    eth_d    = eth_q;
    udp_d    = udp_q;
    amatch_d = amatch_q;
    phi_d    = phi_q;
    pcap_d   = pcap_q;
    if (eop_acc) begin
      pos_d    = '0;
      eth_d    = 1'b0;
      udp_d    = 1'b0;
      amatch_d = '1;
      phi_d    = '0;
      pcap_d   = '0;
    end else if (byte_acc) begin
      if (pos_q == 6'(ETYPE_OFS)) begin
        eth_d = (pkt_byte_i == ETYPE_HI);
      end else if (pos_q == 6'(ETYPE_OFS + 1)) begin
        eth_d = eth_q && (pkt_byte_i == ETYPE_LO);
      end else if (pos_q == 6'(NEXT_HDR_OFS)) begin
        udp_d = (pkt_byte_i == UDP_PROTO);
      end else if (in_addr) begin
        // byte k of an entry sits at bits 127-8k down; 15-k is ~k
        for (int i = 0; i < int'(ADDRESS_ENTRIES); i++) begin
          amatch_d[i] = amatch_q[i] && (akey_q[i][{~abyte_idx, 3'b000} +: 8] == pkt_byte_i);
        end
      end else if (pos_q == 6'(DST_PORT_OFS)) begin
        phi_d = pkt_byte_i;
      end else if (pos_q == 6'(DST_PORT_OFS + 1)) begin
        pcap_d = {phi_q, pkt_byte_i};
      end
      if (pos_q < 6'(MIN_FRAME_LEN)) begin
        pos_d = pos_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      eth_q    <= 1'b0;
      udp_q    <= 1'b0;
      amatch_q <= '1;
      phi_q    <= '0;
      pcap_q   <= '0;
    end else begin
      pos_q    <= pos_d;
      eth_q    <= eth_d;
      udp_q    <= udp_d;
      amatch_q <= amatch_d;
      phi_q    <= phi_d;
      pcap_q   <= pcap_d;
    end
  end

  // address table: one row per entry, contents unreset
  for (genvar gi = 0; gi < int'(ADDRESS_ENTRIES); gi++) begin : g_addr
    always_ff @(posedge clk_i) begin
      if (addr_wr && (32'(slot_i) == gi)) begin
        akey_q[gi] <= {key_high_i, key_low_i};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        aval_q[gi] <= 1'b0;
      end else if (addr_wr && (32'(slot_i) == gi)) begin
        aval_q[gi] <= entry_valid_i;
      end
    end
  end

  // port table
  for (genvar gj = 0; gj < int'(PORT_ENTRIES); gj++) begin : g_port
    always_ff @(posedge clk_i) begin
      if (port_wr && (32'(slot_i) == gj)) begin
        pkey_q[gj] <= port_key_i;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pval_q[gj] <= 1'b0;
      end else if (port_wr && (32'(slot_i) == gj)) begin
        pval_q[gj] <= entry_valid_i;
      end
    end
    assign phit[gj] = pval_q[gj] && (pkey_q[gj] == pcap_q);
  end

  // on the final byte every field that matters is already registered
  // (a frame that ends before byte 61 fails the length test anyway)
  assign tok_push_o     = eop_acc;
  assign tok_o.cand     = (pos_q >= 6'(MIN_FRAME_LEN - 1)) && eth_q && udp_q &&
                          (|(aval_q & amatch_q));
  assign tok_o.port_hit = |phit;
  assign tok_o.rx_queue = rx_queue_i;

endmodule

>>> rtl/core/ipv6urc_fifo.sv
// Short token queue between front and back.
module ipv6urc_fifo import ipv6urc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  token_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output token_t data_o,
  output logic   empty_o
);

  token_t                 mem_q [MID_DEPTH];
  logic [MID_PTR_W-1:0]   wr_q, rd_q;
  logic [MID_CNT_W-1:0]   cnt_q;
  logic                   do_push, do_pop;

  assign full_o  = (cnt_q == MID_CNT_W'(MID_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == MID_PTR_W'(MID_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == MID_PTR_W'(MID_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/ipv6urc_back.sv
// Back part: resolves the verdict and holds the result for the receiver.
module ipv6urc_back import ipv6urc_pkg::*; #(
  parameter int unsigned QUEUE_COUNT = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  token_t             tok_i,
  input  logic               tok_valid_i,
  output logic               tok_pop_o,
  input  logic [QMASK_W-1:0] queue_ready_mask_i,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [1:0]         verdict_o,
  output logic [3:0]         target_queue_o
);

  logic       out_valid_q;
  verdict_e   verdict_q, verdict_d;
  logic [3:0] target_q, target_d;
  logic       q_ready;

  // load when the output slot is free or being drained this cycle
  assign tok_pop_o = tok_valid_i && (!out_valid_q || pop_i);
  assign q_ready   = (32'(tok_i.rx_queue) < QUEUE_COUNT) && queue_ready_mask_i[tok_i.rx_queue];

  always_comb begin
    verdict_d = VERDICT_PASS;
    target_d  = '0;
    if (tok_i.cand && tok_i.port_hit) begin
      if (q_ready) begin
        verdict_d = VERDICT_REDIRECT;
        target_d  = tok_i.rx_queue;
      end else begin
        verdict_d = VERDICT_DROP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tok_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_pop_o) begin
      verdict_q <= verdict_d;
      target_q  <= target_d;
    end
  end

  assign empty_o        = !out_valid_q;
  assign verdict_o      = verdict_q;
  assign target_queue_o = target_q;

endmodule

>>> verif/classifier_verdict_checker.sv
// Verdict predictor and result checker for the IPv6/UDP redirect classifier.
`timescale 1ns / 1ps
module classifier_verdict_checker import ipv6urc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  pkt_byte_i,
  input  logic        end_of_packet_i,
  input  logic [3:0]  rx_queue_i,
  input  logic [3:0]  slot_i,
  input  logic [63:0] key_high_i,
  input  logic [63:0] key_low_i,
  input  logic [15:0] port_key_i,
  input  logic        entry_valid_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [1:0]  verdict_i,
  input  logic [3:0]  target_queue_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          pass_count_o,
  output int          redirect_count_o,
  output int          drop_count_o
);

  localparam int unsigned NUM_ADDR  = 16;
  localparam int unsigned NUM_PORT  = 16;
  localparam int unsigned NUM_QUEUE = 16;

  typedef struct packed {
    verdict_e   verdict;
    logic [3:0] target;
  } verdict_item_t;

  verdict_item_t pending_verdicts[$];

  logic [15:0] ready_mask;
  logic [5:0]  byte_pos;
  logic        etype_ok;
  logic        udp_ok;
  logic [15:0] addr_match;
  logic [7:0]  port_hi;
  logic [15:0] port_seen;
  logic [63:0] addr_upper [NUM_ADDR];
  logic [63:0] addr_lower [NUM_ADDR];
  logic [15:0] addr_valid;
  logic [15:0] port_table [NUM_PORT];
  logic [15:0] port_valid;
  int errors, n_pass, n_redirect, n_drop;

  function automatic logic [7:0] entry_addr_byte(int unsigned e, int unsigned k);
    logic [63:0] w;
    w = (k < 8) ? addr_upper[e] : addr_lower[e];
    return w[63 - 8 * (k % 8) -: 8];
  endfunction

  task automatic clear_frame();
    byte_pos   = '0;
    etype_ok   = 1'b0;
    udp_ok     = 1'b0;
    addr_match = '1;
    port_hi    = '0;
    port_seen  = '0;
  endtask

  task automatic absorb_byte(logic [7:0] b);
    int unsigned pos;
    int unsigned e;
    pos = byte_pos;
    if (pos == ETYPE_OFS) begin
      etype_ok = (b == ETYPE_HI);
    end else if (pos == ETYPE_OFS + 1) begin
      etype_ok = etype_ok && (b == ETYPE_LO);
    end else if (pos == NEXT_HDR_OFS) begin
      udp_ok = (b == UDP_PROTO);
    end else if (pos >= DST_ADDR_OFS && pos < DST_ADDR_OFS + ADDR_BYTES) begin
      for (e = 0; e < NUM_ADDR; e++)
        if (entry_addr_byte(e, pos - DST_ADDR_OFS) != b) addr_match[e] = 1'b0;
    end else if (pos == DST_PORT_OFS) begin
      port_hi = b;
    end else if (pos == DST_PORT_OFS + 1) begin
      port_seen = {port_hi, b};
    end
    if (pos < MIN_FRAME_LEN) byte_pos = 6'(pos + 1);
  endtask

  function automatic verdict_item_t classify_frame(logic [3:0] q);
    verdict_item_t r;
    logic          addr_hit;
    logic          port_hit;
    int unsigned   e;
    addr_hit = |(addr_match & addr_valid);
    port_hit = 1'b0;
    for (e = 0; e < NUM_PORT; e++)
      if (port_valid[e] && port_table[e] == port_seen) port_hit = 1'b1;
    r.target = '0;
    if (byte_pos < MIN_FRAME_LEN || !etype_ok || !addr_hit || !udp_ok || !port_hit) begin
      r.verdict = VERDICT_PASS;
    end else if (q < NUM_QUEUE && ready_mask[q]) begin
      r.verdict = VERDICT_REDIRECT;
      r.target  = q;
    end else begin
      r.verdict = VERDICT_DROP;
    end
    return r;
  endfunction

  task automatic check_result();
    verdict_item_t exp;
    if (pending_verdicts.size() == 0) begin
      errors++;
      $display("%0t: verdict with nothing expected: verdict %0d queue %0d",
               $time, verdict_i, target_queue_i);
    end else begin
      exp = pending_verdicts.pop_front();
      if (verdict_i !== exp.verdict) begin
        errors++;
        $display("%0t: verdict mismatch: expected %0d actual %0d",
                 $time, exp.verdict, verdict_i);
      end
      if (target_queue_i !== exp.target) begin
        errors++;
        $display("%0t: target_queue mismatch: expected %0d actual %0d",
                 $time, exp.target, target_queue_i);
      end
    end
  endtask

  task automatic take_item();
    verdict_item_t v;
    case (mode_e'(mode_i))
      MODE_ADDR: begin
        if (slot_i < NUM_ADDR) begin
          addr_upper[slot_i] = key_high_i;
          addr_lower[slot_i] = key_low_i;
          addr_valid[slot_i] = entry_valid_i;
        end
      end
      MODE_PORT: begin
        if (slot_i < NUM_PORT) begin
          port_table[slot_i] = port_key_i;
          port_valid[slot_i] = entry_valid_i;
        end
      end
      MODE_BYTE: begin
        absorb_byte(pkt_byte_i);
        if (end_of_packet_i) begin
          v = classify_frame(rx_queue_i);
          pending_verdicts.push_back(v);
          case (v.verdict)
            VERDICT_PASS:     n_pass++;
            VERDICT_REDIRECT: n_redirect++;
            default:          n_drop++;
          endcase
          clear_frame();
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_mask = '0;
      clear_frame();
      addr_valid = '0;
      port_valid = '0;
      for (int e = 0; e < NUM_ADDR; e++) begin
        addr_upper[e] = '0;
        addr_lower[e] = '0;
        port_table[e] = '0;
      end
      pending_verdicts.delete();
      errors     = 0;
      n_pass     = 0;
      n_redirect = 0;
      n_drop     = 0;
    end else begin
      if (pop_i && !empty_i) check_result();
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[2] == REG_QMASK)
        ready_mask = pwdata_i[15:0];
      if (push_i && !full_i) take_item();
    end
    fail_count_o     <= errors;
    pending_o        <= pending_verdicts.size();
    pass_count_o     <= n_pass;
    redirect_count_o <= n_redirect;
    drop_count_o     <= n_drop;
  end

endmodule

>>> verif/tb_ipv6_udp_redirect_classifier.sv
// Testbench top for the IPv6/UDP redirect classifier: stimulus, flow control, verdict.
`timescale 1ns / 1ps
module tb_ipv6_udp_redirect_classifier;
  import ipv6urc_pkg::*;

  localparam int unsigned NUM_SLOTS        = 16;
  localparam logic [1:0]  MODE_UNUSED      = 2'd3;  // no such operation, block ignores it
  localparam logic [2:0]  QMASK_ADDR       = 3'd0;
  localparam int unsigned TOTAL_ITEMS      = 1050;
  localparam int unsigned NUM_PHASES       = 4;
  localparam int unsigned BURST_FRAMES     = 8;
  // two register stages plus the token queue; generous margin
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned DRAIN_LIMIT      = 100000;

  typedef enum int {
    FLAW_NONE,
    FLAW_ETYPE_HI,
    FLAW_ETYPE_LO,
    FLAW_NEXT_HDR,
    FLAW_ADDR,
    FLAW_PORT
  } flaw_e;

  // DUT-facing signals; the inputs are known from time zero
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        push            = 1'b0;
  logic        full;
  logic [1:0]  mode_i          = MODE_BYTE;
  logic [7:0]  pkt_byte_i      = '0;
  logic        end_of_packet_i = 1'b0;
  logic [3:0]  rx_queue_i      = '0;
  logic [3:0]  slot_i          = '0;
  logic [63:0] key_high_i      = '0;
  logic [63:0] key_low_i       = '0;
  logic [15:0] port_key_i      = '0;
  logic        entry_valid_i   = 1'b0;
  logic        empty;
  logic        pop             = 1'b0;
  logic [1:0]  verdict_o;
  logic [3:0]  target_queue_o;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [2:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, pending, n_pass, n_redirect, n_drop;

  // flow-control profile, percent of cycles
  int idle_pct  = 0;
  int stall_pct = 0;

  int n_items, n_table_writes, n_frames, n_ignored, n_masks;

  // what was last written to each table slot; used to aim frames at entries and to rewrite an entry
  logic [63:0] sh_addr_hi  [NUM_SLOTS];
  logic [63:0] sh_addr_lo  [NUM_SLOTS];
  logic        sh_addr_vld [NUM_SLOTS];
  logic [15:0] sh_port     [NUM_SLOTS];
  logic        sh_port_vld [NUM_SLOTS];

  logic [7:0] frame_q[$];

  ipv6_udp_redirect_classifier u_top (.*);

  classifier_verdict_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_i           (full),
    .mode_i           (mode_i),
    .pkt_byte_i       (pkt_byte_i),
    .end_of_packet_i  (end_of_packet_i),
    .rx_queue_i       (rx_queue_i),
    .slot_i           (slot_i),
    .key_high_i       (key_high_i),
    .key_low_i        (key_low_i),
    .port_key_i       (port_key_i),
    .entry_valid_i    (entry_valid_i),
    .empty_i          (empty),
    .pop_i            (pop),
    .verdict_i        (verdict_o),
    .target_queue_i   (target_queue_o),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .pready_i         (pready),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .pass_count_o     (n_pass),
    .redirect_count_o (n_redirect),
    .drop_count_o     (n_drop)
  );

  always #4 clk_i = ~clk_i;

  // Result side: pop independently of the sender, stalling per the current profile.
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= stall_pct);
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // One item on the input queue. Idle cycles first, then hold push until full is seen low after an edge.
  // The field values stay on the bus after acceptance; push only drops on idle.
  task automatic send_item(logic [1:0] mode, logic [7:0] b, logic eop, logic [3:0] rxq,
                           logic [3:0] slot, logic [63:0] hi, logic [63:0] lo,
                           logic [15:0] pk, logic vld);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push            <= 1'b1;
    mode_i          <= mode;
    pkt_byte_i      <= b;
    end_of_packet_i <= eop;
    rx_queue_i      <= rxq;
    slot_i          <= slot;
    key_high_i      <= hi;
    key_low_i       <= lo;
    port_key_i      <= pk;
    entry_valid_i   <= vld;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (mode == MODE_UNUSED) n_ignored++;
    else n_items++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic ignored_item();
    send_item(MODE_UNUSED, 8'($urandom), 1'($urandom), 4'($urandom), 4'($urandom),
              rand64(), rand64(), 16'($urandom), 1'($urandom));
  endtask

  // Table writes carry junk in the byte fields; eop means nothing outside byte mode.
  task automatic write_addr_slot(int unsigned s, logic [63:0] hi, logic [63:0] lo, logic vld);
    sh_addr_hi[s]  = hi;
    sh_addr_lo[s]  = lo;
    sh_addr_vld[s] = vld;
    send_item(MODE_ADDR, 8'($urandom), 1'($urandom), 4'($urandom), 4'(s), hi, lo,
              16'($urandom), vld);
    n_table_writes++;
  endtask

  task automatic write_port_slot(int unsigned s, logic [15:0] pk, logic vld);
    sh_port[s]     = pk;
    sh_port_vld[s] = vld;
    send_item(MODE_PORT, 8'($urandom), 1'($urandom), 4'($urandom), 4'(s), rand64(),
              rand64(), pk, vld);
    n_table_writes++;
  endtask

  task automatic random_table_write();
    int unsigned s;
    logic        vld;
    s   = $urandom_range(NUM_SLOTS - 1);
    vld = ($urandom_range(9) != 0);
    if ($urandom_range(1)) write_addr_slot(s, rand64(), rand64(), vld);
    else write_port_slot(s, 16'($urandom), vld);
  endtask

  task automatic write_ready_mask(logic [15:0] m);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= QMASK_ADDR;
    pwdata  <= {16'($urandom), m};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_masks++;
  endtask

  // Stop sending until every verdict is out, then let the pipe settle.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] flip_bits();
    return 8'($urandom_range(1, 255));
  endfunction

  // Well-formed Ethernet/IPv6/UDP frame aimed at address slot a and port slot p,
  // with at most one field spoiled, cut to len bytes (padded out when longer).
  task automatic build_frame(int unsigned a, int unsigned p, flaw_e flaw, int unsigned len);
    int unsigned  n;
    int unsigned  k;
    logic [127:0] dst;
    n = (len > MIN_FRAME_LEN) ? len : MIN_FRAME_LEN;
    frame_q.delete();
    repeat (n) frame_q.push_back(8'($urandom));
    frame_q[ETYPE_OFS]     = ETYPE_HI;
    frame_q[ETYPE_OFS + 1] = ETYPE_LO;
    frame_q[IP6_HDR_OFS]   = {4'h6, 4'($urandom)};
    frame_q[NEXT_HDR_OFS]  = UDP_PROTO;
    dst = {sh_addr_hi[a], sh_addr_lo[a]};
    for (k = 0; k < ADDR_BYTES; k++) frame_q[DST_ADDR_OFS + k] = dst[127 - 8 * k -: 8];
    frame_q[DST_PORT_OFS]     = sh_port[p][15:8];
    frame_q[DST_PORT_OFS + 1] = sh_port[p][7:0];
    case (flaw)
      FLAW_ETYPE_HI: k = ETYPE_OFS;
      FLAW_ETYPE_LO: k = ETYPE_OFS + 1;
      FLAW_NEXT_HDR: k = NEXT_HDR_OFS;
      FLAW_ADDR:     k = DST_ADDR_OFS + $urandom_range(ADDR_BYTES - 1);
      FLAW_PORT:     k = DST_PORT_OFS + $urandom_range(1);
      default:       k = 0;
    endcase
    if (flaw != FLAW_NONE) frame_q[k] = frame_q[k] ^ flip_bits();
    while (frame_q.size() > len) void'(frame_q.pop_back());
  endtask

  // Bytes first..last of the built frame. rx_queue is junk except on the final byte.
  // inject_pct: chance of slipping a table write or an ignored item in before a byte.
  task automatic send_bytes(int unsigned first, int unsigned last, logic [3:0] rxq,
                            int inject_pct);
    int unsigned i;
    logic        eop;
    for (i = first; i <= last; i++) begin
      if ($urandom_range(99) < inject_pct) begin
        if ($urandom_range(4) < 2) ignored_item();
        else random_table_write();
      end
      eop = (i == frame_q.size() - 1);
      send_item(MODE_BYTE, frame_q[i], eop, eop ? rxq : 4'($urandom), 4'($urandom),
                rand64(), rand64(), 16'($urandom), 1'($urandom));
    end
    if (last == frame_q.size() - 1) n_frames++;
  endtask

  task automatic send_frame(logic [3:0] rxq, int inject_pct);
    send_bytes(0, frame_q.size() - 1, rxq, inject_pct);
  endtask

  // Back-to-back single-byte frames: one verdict per item, so stalls fill the queue.
  task automatic short_burst(int unsigned count);
    repeat (count) begin
      build_frame(0, 0, FLAW_NONE, 1);
      send_frame(4'($urandom), 0);
    end
  endtask

  // Prefer slots that are currently valid so most good frames can hit.
  function automatic int unsigned pick_addr_slot();
    int unsigned s;
    s = $urandom_range(NUM_SLOTS - 1);
    repeat (4) if (!sh_addr_vld[s]) s = $urandom_range(NUM_SLOTS - 1);
    return s;
  endfunction

  function automatic int unsigned pick_port_slot();
    int unsigned s;
    s = $urandom_range(NUM_SLOTS - 1);
    repeat (4) if (!sh_port_vld[s]) s = $urandom_range(NUM_SLOTS - 1);
    return s;
  endfunction

  // Half of them well-formed frames; the rest have one bad field or are cut short.
  task automatic random_frame();
    int unsigned r;
    int unsigned len;
    flaw_e       flaw;
    r    = $urandom_range(99);
    flaw = FLAW_NONE;
    if (r < 50) begin
      len = ($urandom_range(3) == 0) ? MIN_FRAME_LEN : MIN_FRAME_LEN + $urandom_range(24);
    end else if (r < 75) begin
      flaw = flaw_e'($urandom_range(FLAW_ETYPE_HI, FLAW_PORT));
      len  = MIN_FRAME_LEN + $urandom_range(8);
    end else begin
      len = $urandom_range(1) ? $urandom_range(1, 12) : $urandom_range(1, MIN_FRAME_LEN - 1);
    end
    build_frame(pick_addr_slot(), pick_port_slot(), flaw, len);
    send_frame(4'($urandom), 2);
    if ($urandom_range(9) == 0) random_table_write();
    if ($urandom_range(19) == 0) ignored_item();
  endtask

  function automatic logic [15:0] mask_for_phase(int unsigned p);
    case (p)
      0, 5:    return 16'hFFFF;
      1, 4:    return 16'h0000;
      3:       return 16'hA5C3;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned s;
    int unsigned p;
    int unsigned items_base;
    int unsigned rand_budget;
    int unsigned c;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // low queues ready, high queues not: both redirect and drop reachable
    write_ready_mask(16'h00FF);

    // Fill every slot once so no entry is ever compared while unwritten.
    // Extremes in slots 0 and 1, slot 15 left invalid.
    write_addr_slot(0, '0, '0, 1'b1);
    write_addr_slot(1, '1, '1, 1'b1);
    for (s = 2; s < NUM_SLOTS; s++) write_addr_slot(s, rand64(), rand64(), s != NUM_SLOTS - 1);
    write_port_slot(0, 16'h0000, 1'b1);
    write_port_slot(1, 16'hFFFF, 1'b1);
    for (s = 2; s < NUM_SLOTS; s++) write_port_slot(s, 16'($urandom), s != NUM_SLOTS - 1);

    // clean hits: ready queue, not-ready queue, minimum length
    build_frame(0, 0, FLAW_NONE, MIN_FRAME_LEN);
    send_frame(4'd0, 0);
    build_frame(1, 1, FLAW_NONE, 70);
    send_frame(4'd15, 0);
    build_frame(2, 2, FLAW_NONE, MIN_FRAME_LEN);
    send_frame(4'd7, 0);
    // too short: a single byte, and one byte under the minimum
    build_frame(3, 3, FLAW_NONE, 1);
    send_frame(4'd3, 0);
    build_frame(3, 3, FLAW_NONE, MIN_FRAME_LEN - 1);
    send_frame(4'd3, 0);
    // each header field spoiled in turn
    for (p = FLAW_ETYPE_HI; p <= FLAW_PORT; p++) begin
      build_frame(4, 4, flaw_e'(p), MIN_FRAME_LEN);
      send_frame(4'd3, 0);
    end
    // address entry rewritten halfway through the destination address:
    // the bytes already seen were checked against the old key
    build_frame(5, 5, FLAW_NONE, 66);
    send_bytes(0, DST_ADDR_OFS + 7, 4'd1, 0);
    write_addr_slot(5, rand64(), rand64(), 1'b1);
    send_bytes(DST_ADDR_OFS + 8, frame_q.size() - 1, 4'd1, 0);
    // port entry dropped just before the last two bytes, with an ignored item in between
    build_frame(6, 6, FLAW_NONE, MIN_FRAME_LEN);
    send_bytes(0, MIN_FRAME_LEN - 3, 4'd4, 0);
    write_port_slot(6, sh_port[6], 1'b0);
    ignored_item();
    send_bytes(MIN_FRAME_LEN - 2, MIN_FRAME_LEN - 1, 4'd4, 0);
    write_port_slot(6, sh_port[6], 1'b1);
    // entry removed, then restored with the same key
    write_addr_slot(7, sh_addr_hi[7], sh_addr_lo[7], 1'b0);
    build_frame(7, 7, FLAW_NONE, MIN_FRAME_LEN);
    send_frame(4'd5, 0);
    write_addr_slot(7, sh_addr_hi[7], sh_addr_lo[7], 1'b1);
    build_frame(7, 7, FLAW_NONE, MIN_FRAME_LEN);
    send_frame(4'd5, 0);

    // Random part: per phase a new mask, written with the pipe empty, and one of
    // four flow-control profiles (none, sender idle, receiver stall, both).
    // Each phase opens with a burst of one-byte frames so stalls fill the queue;
    // the rest of the item budget is split evenly over the phases.
    items_base  = n_items;
    rand_budget = (items_base < TOTAL_ITEMS) ? TOTAL_ITEMS - items_base : 0;
    for (p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      write_ready_mask(mask_for_phase(p));
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      short_burst(BURST_FRAMES);
      do random_frame();
      while (n_items < items_base + rand_budget * (p + 1) / NUM_PHASES);
    end

    // Drain: everything sent, wait for the last verdicts with a bound.
    push <= 1'b0;
    @(posedge clk_i);
    for (c = 0; c < DRAIN_LIMIT && pending != 0; c++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending != 0) $display("%0t: %0d verdicts never arrived", $time, pending);

    $display("Covered %0d frames (%0d pass, %0d redirect, %0d drop), %0d table writes,",
             n_frames, n_pass, n_redirect, n_drop, n_table_writes);
    $display("%0d byte and table items, %0d ignored items, %0d queue-ready masks.",
             n_items, n_ignored, n_masks);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
